// ----- src/plant_cell_maintenance_death_assert.svh -----
// Assertion macros for the plant cell maintenance and death block.
// Included by the top level; depends on nothing else.
`ifndef PLANT_CELL_MAINTENANCE_DEATH_ASSERT_SVH
`define PLANT_CELL_MAINTENANCE_DEATH_ASSERT_SVH
`ifndef SYNTHESIS
`define PCMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PCMD_ASSERT_DLY(label, clk, rst_n, ante, lat, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
    else $error(msg);
`else
`define PCMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCMD_ASSERT_DLY(label, clk, rst_n, ante, lat, cons, msg)
`endif
`endif

// ----- src/pcmd_pkg.sv -----
// Shared constants, types and helpers for the plant cell maintenance block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pcmd_pkg;

  localparam int VALUE_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int HEALTH_BITS = FRAC_BITS + 1;
  localparam int DEN_BITS    = VALUE_BITS + 1;
  localparam int QUO_BITS    = FRAC_BITS + 1;
  localparam int POST_STAGES = 7;
  localparam int LATENCY     = 1 + QUO_BITS + POST_STAGES;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [VALUE_BITS-1:0]  VMAX = {VALUE_BITS{1'b1}};
  localparam logic [HEALTH_BITS-1:0] ONE  = HEALTH_BITS'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STAGE_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SUGAR_DEMAND   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WATER_BASE     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WATER_LIGHT    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIGHT_HALF     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SUGAR_GAIN     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WATER_GAIN     = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGEN_STEP     = 3'd7;

  typedef struct packed {
    logic                  stage_enable;
    logic [VALUE_BITS-1:0] sugar_demand;
    logic [VALUE_BITS-1:0] water_base_demand;
    logic [VALUE_BITS-1:0] water_light_demand;
    logic [VALUE_BITS-1:0] light_half_saturation;
    logic [VALUE_BITS-1:0] sugar_damage_gain;
    logic [VALUE_BITS-1:0] water_damage_gain;
    logic [VALUE_BITS-1:0] regen_step;
  } cfg_t;

  typedef struct packed {
    logic                   active;
    logic [VALUE_BITS-1:0]  sugar;
    logic [VALUE_BITS-1:0]  sdef;
    logic [VALUE_BITS-1:0]  water;
    logic [VALUE_BITS-1:0]  mineral;
    logic [HEALTH_BITS-1:0] health;
    logic [VALUE_BITS-1:0]  dwater;
    logic [VALUE_BITS-1:0]  dmineral;
  } cell_t;

  typedef struct packed {
    cell_t                 item;
    logic [VALUE_BITS-1:0] wdef;
    logic [VALUE_BITS-1:0] wlq;
    logic [VALUE_BITS-1:0] regen;
    logic [VALUE_BITS-1:0] wdem;
    logic [VALUE_BITS-1:0] sdmg;
    logic [VALUE_BITS-1:0] wdmg;
    logic [VALUE_BITS-1:0] dmg;
    logic [VALUE_BITS:0]   hsum;
    logic                  died;
  } post_t;

  // Saturate a sum that grew by one bit.
  function automatic logic [VALUE_BITS-1:0] sat_add(input logic [VALUE_BITS-1:0] a,
                                                    input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_BITS] ? VMAX : s[VALUE_BITS-1:0];
  endfunction

  // Fixed-point product, shifted down and saturated.
  function automatic logic [VALUE_BITS-1:0] mul_q(input logic [VALUE_BITS-1:0] a,
                                                  input logic [VALUE_BITS-1:0] b);
    logic [2*VALUE_BITS-1:0] p;
    logic [2*VALUE_BITS-1:0] sh;
    p  = {{VALUE_BITS{1'b0}}, a} * {{VALUE_BITS{1'b0}}, b};
    sh = p >> FRAC_BITS;
    return (sh > {{VALUE_BITS{1'b0}}, VMAX}) ? VMAX : sh[VALUE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/pcmd_divider.sv -----
// Pipelined restoring divider computing light * ONE / (light + half), one
// quotient bit per stage, with the cell payload riding alongside. Uses pcmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcmd_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [pcmd_pkg::VALUE_BITS-1:0] in_num,
  input  logic [pcmd_pkg::DEN_BITS-1:0]   in_den,
  input  pcmd_pkg::cell_t                 in_cell,
  output logic                            out_valid,
  output logic [pcmd_pkg::QUO_BITS-1:0]   out_quo,
  output pcmd_pkg::cell_t                 out_cell
);
  import pcmd_pkg::*;

  logic [QUO_BITS-1:0] valid_r, valid_nxt;
  logic [DEN_BITS-1:0] rem_r [QUO_BITS];
  logic [DEN_BITS-1:0] rem_nxt [QUO_BITS];
  logic [DEN_BITS-1:0] den_r [QUO_BITS];
  logic [DEN_BITS-1:0] den_nxt [QUO_BITS];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS];
  logic [QUO_BITS-1:0] quo_nxt [QUO_BITS];
  cell_t               cell_r [QUO_BITS];
  cell_t               cell_nxt [QUO_BITS];

  always_comb begin
    logic [DEN_BITS-1:0] prem;
    logic [DEN_BITS-1:0] pden;
    logic [QUO_BITS-1:0] pquo;
    logic [DEN_BITS:0]   trial;
    logic                ge;
    for (int k = 0; k < QUO_BITS; k++) begin
      if (k == 0) begin
        valid_nxt[k] = in_valid;
        prem         = {1'b0, in_num};
        pden         = in_den;
        pquo         = '0;
        cell_nxt[k]  = in_cell;
        trial        = {1'b0, prem};
      end else begin
        valid_nxt[k] = valid_r[k-1];
        prem         = rem_r[k-1];
        pden         = den_r[k-1];
        pquo         = quo_r[k-1];
        cell_nxt[k]  = cell_r[k-1];
        trial        = {prem, 1'b0};
      end
      ge          = trial >= {1'b0, pden};
      rem_nxt[k]  = ge ? DEN_BITS'(trial - {1'b0, pden}) : trial[DEN_BITS-1:0];
      den_nxt[k]  = pden;
      quo_nxt[k]  = {pquo[QUO_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quo_r  <= quo_nxt;
    cell_r <= cell_nxt;
  end

  // A zero denominator gives a zero light term.
  assign out_valid = valid_r[QUO_BITS-1];
  assign out_quo   = (den_r[QUO_BITS-1] == '0) ? '0 : quo_r[QUO_BITS-1];
  assign out_cell  = cell_r[QUO_BITS-1];

endmodule
`default_nettype wire

// ----- src/pcmd_update.sv -----
// Back half of the pipeline: water demand, deficits, damage, regeneration,
// health clamp and death handling. Uses pcmd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcmd_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pcmd_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  input  logic [pcmd_pkg::QUO_BITS-1:0]   in_term,
  input  pcmd_pkg::cell_t                 in_cell,
  output logic                            out_valid,
  output logic                            out_died,
  output logic [pcmd_pkg::VALUE_BITS-1:0] out_sugar,
  output logic [pcmd_pkg::VALUE_BITS-1:0] out_water,
  output logic [pcmd_pkg::VALUE_BITS-1:0] out_mineral,
  output logic [pcmd_pkg::HEALTH_BITS-1:0] out_health,
  output logic [pcmd_pkg::VALUE_BITS-1:0] out_dwater,
  output logic [pcmd_pkg::VALUE_BITS-1:0] out_dmineral
);
  import pcmd_pkg::*;

  logic [POST_STAGES-1:0] valid_r;
  post_t st_r [POST_STAGES];
  post_t st_nxt [POST_STAGES];

  always_comb begin
    logic [HEALTH_BITS-1:0] room;
    logic [VALUE_BITS:0]    diff;
    // Light-linked water product and regeneration product.
    st_nxt[0]      = '0;
    st_nxt[0].item = in_cell;
    st_nxt[0].wlq  = mul_q(cfg.water_light_demand, VALUE_BITS'(in_term));
    room           = ONE - in_cell.health;
    st_nxt[0].regen = (in_cell.health < ONE) ?
                      mul_q(cfg.regen_step, VALUE_BITS'(room)) : '0;
    // Total water demand.
    st_nxt[1]      = st_r[0];
    st_nxt[1].wdem = sat_add(cfg.water_base_demand, st_r[0].wlq);
    // Water deduction.
    st_nxt[2] = st_r[1];
    if (st_r[1].item.active) begin
      if (st_r[1].item.water >= st_r[1].wdem) begin
        st_nxt[2].item.water = st_r[1].item.water - st_r[1].wdem;
      end else begin
        st_nxt[2].wdef       = st_r[1].wdem - st_r[1].item.water;
        st_nxt[2].item.water = '0;
      end
    end
    // Damage terms.
    st_nxt[3]      = st_r[2];
    st_nxt[3].sdmg = mul_q(cfg.sugar_damage_gain, st_r[2].item.sdef);
    st_nxt[3].wdmg = mul_q(cfg.water_damage_gain, st_r[2].wdef);
    // Total damage and health plus regeneration.
    st_nxt[4]      = st_r[3];
    st_nxt[4].dmg  = sat_add(st_r[3].sdmg, st_r[3].wdmg);
    st_nxt[4].hsum = {{(VALUE_BITS + 1 - HEALTH_BITS){1'b0}}, st_r[3].item.health} +
                     ((st_r[3].item.sdef == '0 && st_r[3].wdef == '0) ?
                      {1'b0, st_r[3].regen} : '0);
    // Clamp health to the range zero to one.
    st_nxt[5] = st_r[4];
    diff      = st_r[4].hsum - {1'b0, st_r[4].dmg};
    if (st_r[4].item.active) begin
      if ({1'b0, st_r[4].dmg} >= st_r[4].hsum) begin
        st_nxt[5].item.health = '0;
      end else if (diff > {{(VALUE_BITS + 1 - HEALTH_BITS){1'b0}}, ONE}) begin
        st_nxt[5].item.health = ONE;
      end else begin
        st_nxt[5].item.health = diff[HEALTH_BITS-1:0];
      end
    end
    // Death hands water and mineral to the dead pools.
    st_nxt[6] = st_r[5];
    if (st_r[5].item.active && st_r[5].item.health == '0) begin
      st_nxt[6].died          = 1'b1;
      st_nxt[6].item.dwater   = sat_add(st_r[5].item.dwater, st_r[5].item.water);
      st_nxt[6].item.dmineral = sat_add(st_r[5].item.dmineral, st_r[5].item.mineral);
      st_nxt[6].item.sugar    = '0;
      st_nxt[6].item.water    = '0;
      st_nxt[6].item.mineral  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[POST_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_valid    = valid_r[POST_STAGES-1];
  assign out_died     = st_r[POST_STAGES-1].died;
  assign out_sugar    = st_r[POST_STAGES-1].item.sugar;
  assign out_water    = st_r[POST_STAGES-1].item.water;
  assign out_mineral  = st_r[POST_STAGES-1].item.mineral;
  assign out_health   = st_r[POST_STAGES-1].item.health;
  assign out_dwater   = st_r[POST_STAGES-1].item.dwater;
  assign out_dmineral = st_r[POST_STAGES-1].item.dmineral;

endmodule
`default_nettype wire

// ----- src/plant_cell_maintenance_death.sv -----
// A transaction accepted on start passes through the input register and the pipeline below to out_valid.
// Throughput: one cell per cycle; busy is never raised and the receiver cannot stall.
// The pipeline is the 17-stage bit-per-stage light term divider plus seven update stages.
// Reset: synchronous active-low rst_n clears all valid bits and the configuration registers.
// Depends on pcmd_pkg, pcmd_divider, pcmd_update and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "plant_cell_maintenance_death_assert.svh"
module plant_cell_maintenance_death (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcmd_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  cfg_wdata,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_is_plant,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_light_level,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_sugar_in,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_water_in,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_mineral_in,
  input  logic [pcmd_pkg::HEALTH_BITS-1:0] in_health_in,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_dead_water_in,
  input  logic [pcmd_pkg::VALUE_BITS-1:0]  in_dead_mineral_in,
  output logic                             out_valid,
  output logic                             out_died,
  output logic [pcmd_pkg::VALUE_BITS-1:0]  out_sugar_out,
  output logic [pcmd_pkg::VALUE_BITS-1:0]  out_water_out,
  output logic [pcmd_pkg::VALUE_BITS-1:0]  out_mineral_out,
  output logic [pcmd_pkg::HEALTH_BITS-1:0] out_health_out,
  output logic [pcmd_pkg::VALUE_BITS-1:0]  out_dead_water_out,
  output logic [pcmd_pkg::VALUE_BITS-1:0]  out_dead_mineral_out
);
  import pcmd_pkg::*;

  // The pipeline has no backpressure, so a new transaction is taken every cycle that start is high.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. Every stage reads them live, so software must write them only
  // while the pipeline is empty; the block itself does not enforce this.
  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_STAGE_ENABLE: cfg_nxt.stage_enable          = cfg_wdata[0];
        CFG_SUGAR_DEMAND: cfg_nxt.sugar_demand          = cfg_wdata;
        CFG_WATER_BASE:   cfg_nxt.water_base_demand     = cfg_wdata;
        CFG_WATER_LIGHT:  cfg_nxt.water_light_demand    = cfg_wdata;
        CFG_LIGHT_HALF:   cfg_nxt.light_half_saturation = cfg_wdata;
        CFG_SUGAR_GAIN:   cfg_nxt.sugar_damage_gain     = cfg_wdata;
        CFG_WATER_GAIN:   cfg_nxt.water_damage_gain     = cfg_wdata;
        CFG_REGEN_STEP:   cfg_nxt.regen_step            = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input stage: capture the cell, pay the sugar demand and form the divider
  // denominator. Cells that are not live plants, or a disabled stage, leave
  // every field untouched all the way down.
  logic                  in_valid_r;
  cell_t                 cell_r, cell_nxt;
  logic [VALUE_BITS-1:0] light_r;
  logic [DEN_BITS-1:0]   den_r, den_nxt;

  always_comb begin
    cell_nxt          = '0;
    cell_nxt.active   = cfg_r.stage_enable && in_is_plant;
    cell_nxt.sugar    = in_sugar_in;
    cell_nxt.water    = in_water_in;
    cell_nxt.mineral  = in_mineral_in;
    cell_nxt.health   = in_health_in;
    cell_nxt.dwater   = in_dead_water_in;
    cell_nxt.dmineral = in_dead_mineral_in;
    if (cell_nxt.active) begin
      if (in_sugar_in >= cfg_r.sugar_demand) begin
        cell_nxt.sugar = in_sugar_in - cfg_r.sugar_demand;
      end else begin
        cell_nxt.sdef  = cfg_r.sugar_demand - in_sugar_in;
        cell_nxt.sugar = '0;
      end
    end
    den_nxt = {1'b0, in_light_level} + {1'b0, cfg_r.light_half_saturation};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cell_r  <= cell_nxt;
    light_r <= in_light_level;
    den_r   <= den_nxt;
  end

  // Light term, one quotient bit per stage.
  logic                div_valid;
  logic [QUO_BITS-1:0] div_term;
  cell_t               div_cell;

  pcmd_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_num    (light_r),
    .in_den    (den_r),
    .in_cell   (cell_r),
    .out_valid (div_valid),
    .out_quo   (div_term),
    .out_cell  (div_cell)
  );

  // Water demand, deficits, health update and death; its last stage is the
  // output register.
  pcmd_update u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (div_valid),
    .in_term      (div_term),
    .in_cell      (div_cell),
    .out_valid    (out_valid),
    .out_died     (out_died),
    .out_sugar    (out_sugar_out),
    .out_water    (out_water_out),
    .out_mineral  (out_mineral_out),
    .out_health   (out_health_out),
    .out_dwater   (out_dead_water_out),
    .out_dmineral (out_dead_mineral_out)
  );

  // A dead cell leaves nothing behind in its own stores.
  `PCMD_ASSERT_IMP(a_died_clears, clk, rst_n, out_valid && out_died, out_health_out == '0 && out_sugar_out == '0 && out_water_out == '0 && out_mineral_out == '0, "died cell kept its stores")
  // Every accepted transaction comes out after the fixed latency.
  `PCMD_ASSERT_DLY(a_latency, clk, rst_n, accept, LATENCY, out_valid, "result missing after pipeline latency")
  // An updated cell that comes out with health above one is never flagged as died.
  `PCMD_ASSERT_IMP(a_health_range, clk, rst_n, out_valid && u_update.valid_r[POST_STAGES-1] && out_health_out > ONE, !out_died, "died with health above one")

endmodule
`default_nettype wire
